// File: design/hiqpu_pkg.sv
// Shared constants and types for the quadratic-probe hash insert unit.
package hiqpu_pkg;

  localparam int Depth     = 128;
  localparam int MaxProbes = 32;
  localparam int AddrW     = $clog2(Depth);
  localparam int EffW      = $clog2(Depth + 1);
  localparam int ProbeW    = $clog2(MaxProbes + 1);
  localparam int KeyW      = 17;
  localparam int SizeW     = 8;
  localparam int SlotW     = 7;
  localparam int CountW    = 6;
  localparam int CfgIdxW   = 2;

  localparam logic [SizeW-1:0] TableSizeRst  = SizeW'(82);
  localparam logic [KeyW-1:0]  HashOffsetRst = KeyW'(89);

  typedef enum logic [CfgIdxW-1:0] {
    CfgTableSize  = 2'd0,
    CfgHashOffset = 2'd1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    StIdle,
    StDiv,
    StRead,
    StCheck
  } state_e;

endpackage

// File: design/hiqpu_ram.sv
// Generic single-port RAM with a registered read.
module hiqpu_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// File: design/hash_insert_quadratic_probe_unit.sv
// Quadratic-probe open-addressing hash insert: top level with control and slot store.
// A nonzero key passes the remainder loop (two bits a cycle), then a RAM read and then a
// check and write for each slot looked at, and ends in the result register.
// A zero key answers in the cycle after acceptance. Busy falls with the result strobe, so a
// new word can be taken as a result shows (every cycle for zero keys); results cannot stall.
// Reset empties the table at once through per-slot valid bits and loads the registers.
module hash_insert_quadratic_probe_unit
  import hiqpu_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [KeyW-1:0]    key_i,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [KeyW-1:0]    cfg_wdata_i,
  output logic               done_o,
  output logic [SlotW-1:0]   slot_o,
  output logic [CountW-1:0]  probe_count_o,
  output logic               status_o
);

  // The dividend key + offset is one bit wider than a key. It is padded to an even
  // width so the remainder loop can retire two bits per cycle.
  localparam int NumW      = KeyW + 1;
  localparam int DivCycles = (NumW + 1) / 2;
  localparam int NumRegW   = 2 * DivCycles;
  localparam int DivCntW   = $clog2(DivCycles);

  // Configuration registers.
  logic [SizeW-1:0] table_size_q;
  logic [KeyW-1:0]  hash_offset_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_size_q  <= TableSizeRst;
      hash_offset_q <= HashOffsetRst;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgTableSize) begin
        table_size_q <= cfg_wdata_i[SizeW-1:0];
      end else if (cfg_idx_i == CfgHashOffset) begin
        hash_offset_q <= cfg_wdata_i;
      end
    end
  end

  // The size in use: a zero size acts as one, and sizes past the store saturate.
  logic [EffW-1:0] eff_size;

  always_comb begin
    eff_size = EffW'(table_size_q);
    if (table_size_q == '0) begin
      eff_size = EffW'(1);
    end else if (int'(table_size_q) > Depth) begin
      eff_size = EffW'(Depth);
    end
  end

  // Control and datapath registers.
  state_e              state_q, state_d;
  logic [KeyW-1:0]     key_q, key_d;
  logic [EffW-1:0]     size_q, size_d;
  logic [NumRegW-1:0]  num_q, num_d;
  logic [DivCntW-1:0]  div_cnt_q, div_cnt_d;
  logic [EffW-1:0]     rem_q, rem_d;
  logic [AddrW-1:0]    h_q, h_d;
  logic [EffW-1:0]     step_q, step_d;
  logic [ProbeW-1:0]   probe_q, probe_d;
  logic                done_q, done_d;
  logic [SlotW-1:0]    slot_q, slot_d;
  logic [CountW-1:0]   count_q, count_d;
  logic                status_q, status_d;
  logic [Depth-1:0]    vld_q, vld_d;
  logic                rd_vld_q;

  // Slot store. A slot whose valid bit is clear reads as empty, whatever the RAM holds.
  logic               ram_we;
  logic [KeyW-1:0]    ram_rdata;

  hiqpu_ram #(
    .Width (KeyW),
    .Depth (Depth)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (h_q),
    .wdata_i (key_q),
    .rdata_o (ram_rdata)
  );

  // Two restoring remainder steps per cycle on the current dividend bits.
  logic [EffW-1:0] div_rem;
  logic [EffW:0]   div_trial;

  always_comb begin
    div_rem   = rem_q;
    div_trial = '0;
    for (int i = 0; i < 2; i++) begin
      div_trial = {div_rem, num_q[NumRegW-1-i]};
      if (div_trial >= {1'b0, size_q}) begin
        div_trial = div_trial - {1'b0, size_q};
      end
      div_rem = div_trial[EffW-1:0];
    end
  end

  // Next probe position. Consecutive squares differ by 2j+1, so the slot advances by a
  // running increment that is itself kept reduced modulo the size.
  logic [EffW:0] h_sum;
  logic [EffW:0] step_sum;

  always_comb begin
    h_sum = {1'b0, EffW'(h_q)} + {1'b0, step_q};
    if (h_sum >= {1'b0, size_q}) begin
      h_sum = h_sum - {1'b0, size_q};
    end
    step_sum = {1'b0, step_q} + (EffW+1)'(2);
    if (step_sum >= {1'b0, size_q}) begin
      step_sum = step_sum - {1'b0, size_q};
    end
    // A size of one needs the second reduction.
    if (step_sum >= {1'b0, size_q}) begin
      step_sum = step_sum - {1'b0, size_q};
    end
  end

  logic slot_empty;
  assign slot_empty = !rd_vld_q || (ram_rdata == '0);

  always_comb begin
    state_d   = state_q;
    key_d     = key_q;
    size_d    = size_q;
    num_d     = num_q;
    div_cnt_d = div_cnt_q;
    rem_d     = rem_q;
    h_d       = h_q;
    step_d    = step_q;
    probe_d   = probe_q;
    done_d    = 1'b0;
    slot_d    = slot_q;
    count_d   = count_q;
    status_d  = status_q;
    vld_d     = vld_q;
    ram_we    = 1'b0;

    case (state_q)
      StIdle: begin
        if (start) begin
          if (key_i == '0) begin
            // Zero is the empty marker, so the key is refused right away.
            done_d   = 1'b1;
            slot_d   = '0;
            count_d  = '0;
            status_d = 1'b1;
          end else begin
            key_d     = key_i;
            size_d    = eff_size;
            num_d     = NumRegW'({1'b0, key_i} + {1'b0, hash_offset_q});
            div_cnt_d = DivCntW'(DivCycles - 1);
            rem_d     = '0;
            state_d   = StDiv;
          end
        end
      end
      StDiv: begin
        rem_d = div_rem;
        num_d = num_q << 2;
        if (div_cnt_q == '0) begin
          h_d     = AddrW'(div_rem);
          probe_d = '0;
          step_d  = (size_q == EffW'(1)) ? '0 : EffW'(1);
          state_d = StRead;
        end else begin
          div_cnt_d = div_cnt_q - DivCntW'(1);
        end
      end
      StRead: begin
        state_d = StCheck;
      end
      StCheck: begin
        if (slot_empty) begin
          ram_we       = 1'b1;
          vld_d[h_q]   = 1'b1;
          done_d       = 1'b1;
          slot_d       = SlotW'(h_q);
          count_d      = CountW'(probe_q);
          status_d     = 1'b0;
          state_d      = StIdle;
        end else if (probe_q == ProbeW'(MaxProbes)) begin
          // Probe budget spent: report the last slot looked at.
          done_d   = 1'b1;
          slot_d   = SlotW'(h_q);
          count_d  = CountW'(MaxProbes);
          status_d = 1'b1;
          state_d  = StIdle;
        end else begin
          h_d     = AddrW'(h_sum);
          step_d  = step_sum[EffW-1:0];
          probe_d = probe_q + ProbeW'(1);
          state_d = StRead;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      done_q  <= 1'b0;
      vld_q   <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      vld_q   <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    size_q    <= size_d;
    num_q     <= num_d;
    div_cnt_q <= div_cnt_d;
    rem_q     <= rem_d;
    h_q       <= h_d;
    step_q    <= step_d;
    probe_q   <= probe_d;
    slot_q    <= slot_d;
    count_q   <= count_d;
    status_q  <= status_d;
    rd_vld_q  <= vld_q[h_q];
  end

  assign busy          = (state_q != StIdle);
  assign done_o        = done_q;
  assign slot_o        = slot_q;
  assign probe_count_o = count_q;
  assign status_o      = status_q;

`ifndef SYNTHESIS
  // A result only appears once the insert has finished.
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while an insert is in flight");

  // A zero key is refused in the following cycle.
  a_zero_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && key_i == '0) |=> (done_o && status_o))
    else $error("zero key not refused");

  // A placed key never reports more probes than the budget allows.
  a_probe_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !status_o) |-> (int'(probe_count_o) <= MaxProbes))
    else $error("probe count beyond budget");

  // Every slot written lies within the configured table.
  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (EffW'(h_q) < size_q))
    else $error("write outside table");
`endif

endmodule

// File: tb/tb_hash_insert_quadratic_probe_unit.sv
// Self-checking testbench for the quadratic-probe hash insert unit.
module tb_hash_insert_quadratic_probe_unit;
  import hiqpu_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Register indexes that the block has no register for. Writes to them must be ignored.
  localparam logic [CfgIdxW-1:0] CfgSpareLo = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpareHi = 2'd3;

  // Status codes of a result word.
  localparam logic StatusPlaced  = 1'b0;
  localparam logic StatusNoSpace = 1'b1;

  localparam logic [KeyW-1:0] KeyAllOnes = {KeyW{1'b1}};

  // Long enough for the slowest nonzero key, one that uses every probe, so this covers any word in flight.
  localparam int SettleCycles = 16 + 2 * MaxProbes;
  localparam int DrainLimit   = 4000;

  typedef struct packed {
    logic [SlotW-1:0]  slot;
    logic [CountW-1:0] probe_count;
    logic              status;
  } insert_word_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [KeyW-1:0]    key_i = '0;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = CfgTableSize;
  logic [KeyW-1:0]    cfg_wdata_i = '0;
  logic               done_o;
  logic [SlotW-1:0]   slot_o;
  logic [CountW-1:0]  probe_count_o;
  logic               status_o;

  // Mirror of the block's state: the slot store and both registers, as they stand after reset.
  logic [KeyW-1:0]  table_mirror [Depth] = '{default: '0};
  logic [SizeW-1:0] size_mirror   = TableSizeRst;
  logic [KeyW-1:0]  offset_mirror = HashOffsetRst;

  // Result words that accepted keys still owe, oldest first.
  insert_word_t expected_words [$];
  int           mismatch_count = 0;

  hash_insert_quadratic_probe_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .key_i         (key_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .done_o        (done_o),
    .slot_o        (slot_o),
    .probe_count_o (probe_count_o),
    .status_o      (status_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Works out the result word of one insert and applies the insert to the mirrored table.
  // A size of zero behaves as one slot and sizes above the store depth are clipped to it.
  function automatic insert_word_t predict_insert(input logic [KeyW-1:0] key);
    int unsigned  modulus;
    int unsigned  home;
    int unsigned  probe_slot;
    insert_word_t word;
    modulus = size_mirror;
    if (modulus == 0) begin
      modulus = 1;
    end
    if (modulus > Depth) begin
      modulus = Depth;
    end
    // A zero key would look like an empty slot, so it is refused without touching the table.
    if (key == '0) begin
      word = '{slot: '0, probe_count: '0, status: StatusNoSpace};
      return word;
    end
    home = (int'(key) + int'(offset_mirror)) % modulus;
    probe_slot = home;
    if (table_mirror[probe_slot] == '0) begin
      table_mirror[probe_slot] = key;
      word = '{slot: SlotW'(probe_slot), probe_count: '0, status: StatusPlaced};
      return word;
    end
    for (int unsigned j = 1; j <= MaxProbes; j++) begin
      probe_slot = (home + j * j) % modulus;
      if (table_mirror[probe_slot] == '0) begin
        table_mirror[probe_slot] = key;
        word = '{slot: SlotW'(probe_slot), probe_count: CountW'(j), status: StatusPlaced};
        return word;
      end
    end
    // Every probe hit an occupied slot: the word reports the last slot that was looked at.
    word = '{slot: SlotW'(probe_slot), probe_count: CountW'(MaxProbes), status: StatusNoSpace};
    return word;
  endfunction

  // Offers one key and returns at the edge that accepts it. Start is left high so that a
  // following key can go out back to back; a gap or a wait lowers it.
  task automatic send_key(input logic [KeyW-1:0] key);
    start <= 1'b1;
    key_i <= key;
    @(posedge clk_i);
    while (busy) begin
      @(posedge clk_i);
    end
    expected_words.push_back(predict_insert(key));
  endtask

  task automatic sender_gap(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Holds the sender off until every owed word has come back and the block is idle.
  task automatic wait_for_results();
    int waited;
    waited = 0;
    start <= 1'b0;
    while ((expected_words.size() != 0 || busy) && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (3) @(posedge clk_i);
  endtask

  // One register write. Waiting after it keeps the write enable from being lowered and raised
  // again in one time step when writes follow each other.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [KeyW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      CfgTableSize: begin
        size_mirror = data[SizeW-1:0];
      end
      CfgHashOffset: begin
        offset_mirror = data;
      end
      default: begin
      end
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Mostly ordinary keys, with the zero key, the all-ones key and single-bit keys mixed in.
  function automatic logic [KeyW-1:0] random_key();
    logic [KeyW-1:0] key;
    case ($urandom_range(0, 19))
      0: key = '0;
      1: key = KeyAllOnes;
      2: key = KeyW'(1) << $urandom_range(0, KeyW - 1);
      default: key = KeyW'($urandom_range(1, (1 << KeyW) - 1));
    endcase
    return key;
  endfunction

  // Picks a new size and offset. The extremes come up often, and the bits above the size
  // field carry random junk that the block must drop.
  task automatic random_config();
    logic [SizeW-1:0] new_size;
    logic [KeyW-1:0]  new_offset;
    case ($urandom_range(0, 9))
      0: new_size = '0;
      1: new_size = SizeW'(1);
      2: new_size = SizeW'(Depth);
      3: new_size = SizeW'($urandom_range(Depth + 1, (1 << SizeW) - 1));
      default: new_size = SizeW'($urandom_range(2, Depth - 1));
    endcase
    case ($urandom_range(0, 5))
      0: new_offset = '0;
      1: new_offset = KeyAllOnes;
      default: new_offset = KeyW'($urandom);
    endcase
    write_reg(CfgTableSize, {(KeyW - SizeW)'($urandom), new_size});
    write_reg(CfgHashOffset, new_offset);
    if ($urandom_range(0, 2) == 0) begin
      write_reg($urandom_range(0, 1) ? CfgSpareLo : CfgSpareHi, KeyW'($urandom));
    end
  endtask

  task automatic send_random_keys(input int count, input int gap_odds);
    for (int i = 0; i < count; i++) begin
      send_key(random_key());
      if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
        sender_gap($urandom_range(1, 7));
      end
    end
  endtask

  // Reset values of the registers: plain placement, collisions on one home slot that need
  // one and two probes, the zero key, a duplicate key and the key extremes.
  task automatic test_reset_config();
    send_key(KeyW'(1));
    send_key(KeyW'(83));
    sender_gap(3);
    send_key(KeyW'(165));
    send_key(KeyAllOnes);
    send_key('0);
    sender_gap(1);
    send_key(KeyW'(1));
    send_key(KeyW'(1) << (KeyW - 1));
    wait_for_results();
  endtask

  // Writes to unused indexes change nothing; a size of zero acts as a single slot, where the
  // second key runs out of probes; oversized sizes clip to the store depth; both offset
  // extremes are used.
  task automatic test_register_extremes();
    write_reg(CfgSpareLo, KeyAllOnes);
    write_reg(CfgSpareHi, '0);
    send_key(KeyW'(2));
    wait_for_results();
    write_reg(CfgTableSize, {(KeyW - SizeW)'('1), SizeW'(0)});
    write_reg(CfgHashOffset, '0);
    send_key(KeyW'(5));
    send_key(KeyW'(7));
    send_key(KeyW'(9));
    wait_for_results();
    write_reg(CfgTableSize, KeyW'((1 << SizeW) - 1));
    write_reg(CfgHashOffset, KeyAllOnes);
    send_key(KeyAllOnes);
    send_key(KeyW'(1));
    wait_for_results();
    write_reg(CfgTableSize, KeyW'(Depth));
    write_reg(CfgHashOffset, '0);
    send_key(KeyW'(Depth - 1));
    send_key(KeyW'(Depth));
    wait_for_results();
    write_reg(CfgTableSize, {(KeyW - SizeW)'('1) ^ (KeyW - SizeW)'(1), SizeW'(1)});
    send_key(KeyW'(3));
    wait_for_results();
    write_reg(CfgTableSize, KeyW'(2));
    write_reg(CfgHashOffset, KeyW'(1));
    send_key(KeyW'(1));
    send_key(KeyW'(2));
    wait_for_results();
  endtask

  // Random phases, each under a fresh configuration. Every fourth phase runs without any
  // sender gaps; the others idle in bursts at different rates. The wait before each change
  // lets the block run dry with the sender held off.
  task automatic test_random_inserts();
    for (int phase = 0; phase < 12; phase++) begin
      random_config();
      send_random_keys(130, (phase % 4 == 0) ? 0 : 2 + phase % 4);
      wait_for_results();
    end
  endtask

  // The last stretch: start stays high and every word follows the one before without a gap.
  task automatic test_back_to_back();
    random_config();
    send_random_keys(200, 0);
  endtask

  // Each result word is sampled at the edge that ends its strobe cycle and matched against
  // the oldest word still owed.
  always @(posedge clk_i) begin : check_results
    insert_word_t owed;
    if (rst_ni && done_o) begin
      if (expected_words.size() == 0) begin
        $error("result word with none owed: slot %0d, probe_count %0d, status %0d",
               slot_o, probe_count_o, status_o);
        mismatch_count++;
      end else begin
        owed = expected_words.pop_front();
        if (slot_o !== owed.slot) begin
          $error("slot: expected %0d, actual %0d", owed.slot, slot_o);
          mismatch_count++;
        end
        if (probe_count_o !== owed.probe_count) begin
          $error("probe_count: expected %0d, actual %0d", owed.probe_count, probe_count_o);
          mismatch_count++;
        end
        if (status_o !== owed.status) begin
          $error("status: expected %0d, actual %0d", owed.status, status_o);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_reset_config();
    test_register_extremes();
    test_random_inserts();
    test_back_to_back();
    wait_for_results();
    repeat (SettleCycles) @(posedge clk_i);
    if (expected_words.size() != 0) begin
      $error("%0d result words never arrived", expected_words.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // The full run ends long before this timeout even if every key used all its probes, so
  // reaching it means the block has hung.
  initial begin
    #15_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
